// File: hw/rtl/ocp_pkg.sv
// ----------------------------------------------------------------------------
// Orbit camera package
// Shared types, constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ocp_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_START_RADIUS = 2'd0;
  localparam logic [1:0] CFG_START_YAW    = 2'd1;
  localparam logic [1:0] CFG_START_PITCH  = 2'd2;

  // Input item kinds.
  localparam logic FUNC_ROTATE = 1'b0;
  localparam logic FUNC_ZOOM   = 1'b1;

  // Angle constants in Q3.13.
  localparam int ANG_PI      = 25736;
  localparam int ANG_TWO_PI  = 51472;
  localparam int ANG_HALF_PI = 12868;
  localparam int PITCH_LIM   = 12049;

  // Radius and position limits in Q8.8.
  localparam int RADIUS_MIN = 26;
  localparam int RADIUS_MAX = 65535;
  localparam int POS_LIM    = 65535;

  // CORDIC datapath width (Q2.30 plus guard bits) and limits.
  localparam int CW        = 34;
  localparam int MAX_STEPS = 24;
  localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

  // State handed from the front to the back.
  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic [15:0]        radius;
  } ocp_item_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD,
    ST_ITER,
    ST_MUL1,
    ST_MUL2,
    ST_OUT
  } back_state_t;

  // Arctangent of 2^-i in Q2.30.
  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
    logic signed [CW-1:0] v;
    case (i)
      5'd0:  v = 34'sd843314856;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043836;
      5'd3:  v = 34'sd133525158;
      5'd4:  v = 34'sd67021686;
      5'd5:  v = 34'sd33543515;
      5'd6:  v = 34'sd16775850;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194282;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048575;
      5'd11: v = 34'sd524287;
      5'd12: v = 34'sd262143;
      5'd13: v = 34'sd131071;
      5'd14: v = 34'sd65535;
      5'd15: v = 34'sd32767;
      5'd16: v = 34'sd16383;
      5'd17: v = 34'sd8191;
      5'd18: v = 34'sd4095;
      5'd19: v = 34'sd2047;
      5'd20: v = 34'sd1023;
      5'd21: v = 34'sd511;
      5'd22: v = 34'sd255;
      5'd23: v = 34'sd127;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/orbit_camera_position.sv
// Path from an accepted input beat to its output beat: queue, fold, one CORDIC
// micro-rotation per cycle and two multiply steps.
// The back end takes a new item only after the last has left, so the shared CORDIC
// loop (14 steps by default) sets the pace; the two-entry queue absorbs short bursts.
// Reset: synchronous active-low; start registers return to radius 5.0, yaw 0,
// pitch 0 and the camera state is reset to the same values.
// ----------------------------------------------------------------------------
// Orbit camera position
// Keeps yaw, pitch and radius of an orbit camera and returns its position.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module orbit_camera_position #(
  parameter int CORDIC_STEPS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration writes.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // Input beats.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [15:0] delta_a, [31:16] delta_b
  input  wire logic        in_tuser,   // [0] func
  // Output beats.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata   // [16:0] pos_x, [33:17] pos_y, [50:34] pos_z
);

  ocp_pkg::ocp_item_t push_data, pop_data;
  logic               push, pop, q_full, q_empty;
  logic signed [16:0] pos_x, pos_y, pos_z;

  assign cfg_ready = 1'b1;

  ocp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (in_tvalid),
    .item_func  (in_tuser),
    .delta_a    (in_tdata[15:0]),
    .delta_b    (in_tdata[31:16]),
    .q_full     (q_full),
    .item_ready (in_tready),
    .q_push     (push),
    .q_data     (push_data)
  );

  ocp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  ocp_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (pop_data),
    .q_pop     (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .pos_z     (pos_z)
  );

  assign out_tdata = {5'd0, pos_z, pos_y, pos_x};

endmodule

`default_nettype wire

// File: hw/rtl/ocp_fifo.sv
// ----------------------------------------------------------------------------
// Orbit camera item queue
// Two-entry queue between the state-update front and the position back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ocp_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire ocp_pkg::ocp_item_t push_data,
  input  wire logic              pop,
  output ocp_pkg::ocp_item_t     pop_data,
  output logic                   full,
  output logic                   empty
);

  ocp_pkg::ocp_item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3) else $error("queue count out of range");

endmodule

`default_nettype wire

// File: hw/rtl/ocp_front.sv
// ----------------------------------------------------------------------------
// Orbit camera front end
// Holds the start registers and the yaw, pitch and radius state, applies
// rotate and zoom beats and pushes the new state into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ocp_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               item_valid,
  input  wire logic               item_func,
  input  wire logic signed [15:0] delta_a,
  input  wire logic signed [15:0] delta_b,
  input  wire logic               q_full,
  output logic                    item_ready,
  output logic                    q_push,
  output ocp_pkg::ocp_item_t      q_data
);

  logic [15:0]        start_radius_r, start_radius_nxt;
  logic signed [15:0] start_yaw_r, start_yaw_nxt;
  logic signed [14:0] start_pitch_r, start_pitch_nxt;
  logic signed [15:0] cur_yaw_r, cur_yaw_nxt;
  logic signed [15:0] cur_pitch_r, cur_pitch_nxt;
  logic [15:0]        cur_radius_r, cur_radius_nxt;

  logic               reload;
  logic [16:0]        zoom_mag;
  logic [33:0]        zoom_prod;
  logic [11:0]        zoom_q;
  logic signed [17:0] radius_diff;

  // Wrap a yaw into [-pi, pi).
  function automatic logic signed [15:0] wrap_yaw(input logic signed [17:0] v);
    logic signed [17:0] r;
    r = v;
    if (v > 18'(ocp_pkg::ANG_PI - 1)) begin
      r = v - 18'(ocp_pkg::ANG_TWO_PI);
    end else if (v < -18'sd25736) begin
      r = v + 18'(ocp_pkg::ANG_TWO_PI);
    end
    return r[15:0];
  endfunction

  // Clamp a pitch to the symmetric limit.
  function automatic logic signed [15:0] clamp_pitch(input logic signed [17:0] v);
    logic signed [17:0] r;
    r = v;
    if (v > 18'(ocp_pkg::PITCH_LIM)) begin
      r = 18'(ocp_pkg::PITCH_LIM);
    end else if (v < -18'(ocp_pkg::PITCH_LIM)) begin
      r = -18'(ocp_pkg::PITCH_LIM);
    end
    return r[15:0];
  endfunction

  // Clamp a radius to [floor, top].
  function automatic logic [15:0] clamp_radius(input logic signed [17:0] v);
    logic signed [17:0] r;
    r = v;
    if (v < 18'(ocp_pkg::RADIUS_MIN)) begin
      r = 18'(ocp_pkg::RADIUS_MIN);
    end else if (v > 18'(ocp_pkg::RADIUS_MAX)) begin
      r = 18'(ocp_pkg::RADIUS_MAX);
    end
    return r[15:0];
  endfunction

  assign item_ready = !q_full;
  assign q_push     = item_valid && item_ready;
  assign reload     = cfg_valid && (cfg_index == ocp_pkg::CFG_START_RADIUS ||
                                    cfg_index == ocp_pkg::CFG_START_YAW ||
                                    cfg_index == ocp_pkg::CFG_START_PITCH);

  // Zoom step: one tenth of the scroll amount, rounded away from zero on ties.
  // Division by ten is a multiply by 52429 and a shift by 19.
  always_comb begin
    zoom_mag    = delta_a[15] ? 17'(-{delta_a[15], delta_a}) : 17'({1'b0, delta_a});
    zoom_prod   = 34'(zoom_mag + 17'd5) * 34'd52429;
    zoom_q      = zoom_prod[30:19];
    radius_diff = delta_a[15] ? 18'(cur_radius_r) + 18'(zoom_q)
                              : 18'(cur_radius_r) - 18'(zoom_q);
  end

  // Register writes and state update.
  always_comb begin
    start_radius_nxt = start_radius_r;
    start_yaw_nxt    = start_yaw_r;
    start_pitch_nxt  = start_pitch_r;
    cur_yaw_nxt      = cur_yaw_r;
    cur_pitch_nxt    = cur_pitch_r;
    cur_radius_nxt   = cur_radius_r;
    if (cfg_valid) begin
      case (cfg_index)
        ocp_pkg::CFG_START_RADIUS: start_radius_nxt = cfg_data;
        ocp_pkg::CFG_START_YAW:    start_yaw_nxt    = cfg_data;
        ocp_pkg::CFG_START_PITCH:  start_pitch_nxt  = cfg_data[14:0];
        default: ;
      endcase
    end
    if (reload) begin
      cur_yaw_nxt    = wrap_yaw(18'(start_yaw_nxt));
      cur_pitch_nxt  = clamp_pitch(18'(start_pitch_nxt));
      cur_radius_nxt = clamp_radius(18'({1'b0, start_radius_nxt}));
    end else if (q_push) begin
      if (item_func == ocp_pkg::FUNC_ROTATE) begin
        cur_yaw_nxt   = wrap_yaw(18'(cur_yaw_r) + 18'(delta_a));
        cur_pitch_nxt = clamp_pitch(18'(cur_pitch_r) - 18'(delta_b));
      end else begin
        cur_radius_nxt = clamp_radius(radius_diff);
      end
    end
  end

  assign q_data = '{yaw: cur_yaw_nxt, pitch: cur_pitch_nxt, radius: cur_radius_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_radius_r <= 16'd1280;
      start_yaw_r    <= '0;
      start_pitch_r  <= '0;
      cur_yaw_r      <= '0;
      cur_pitch_r    <= '0;
      cur_radius_r   <= 16'd1280;
    end else begin
      start_radius_r <= start_radius_nxt;
      start_yaw_r    <= start_yaw_nxt;
      start_pitch_r  <= start_pitch_nxt;
      cur_yaw_r      <= cur_yaw_nxt;
      cur_pitch_r    <= cur_pitch_nxt;
      cur_radius_r   <= cur_radius_nxt;
    end
  end

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_pitch_r <= 16'(ocp_pkg::PITCH_LIM) && cur_pitch_r >= -16'(ocp_pkg::PITCH_LIM))
    else $error("pitch left its clamp range");
  a_radius_floor: assert property (@(posedge clk) disable iff (!rst_n)
    cur_radius_r >= 16'(ocp_pkg::RADIUS_MIN)) else $error("radius below floor");
  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_yaw_r >= -16'sd25736 && cur_yaw_r <= 16'sd25735) else $error("yaw not wrapped");

endmodule

`default_nettype wire

// File: hw/rtl/ocp_back.sv
// ----------------------------------------------------------------------------
// Orbit camera back end
// Runs two CORDIC lanes (yaw and pitch) side by side, forms the position
// with two multiply steps and holds the result in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ocp_back #(
  parameter int CORDIC_STEPS = 14
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire ocp_pkg::ocp_item_t q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [16:0]      pos_x,
  output logic signed [16:0]      pos_y,
  output logic signed [16:0]      pos_z
);

  localparam int NSTEPS = (CORDIC_STEPS > ocp_pkg::MAX_STEPS) ? ocp_pkg::MAX_STEPS
                                                             : CORDIC_STEPS;
  localparam int CW = ocp_pkg::CW;

  ocp_pkg::back_state_t state_r, state_nxt;

  logic signed [15:0]   ang_r [2];
  logic                 neg_r [2];
  logic signed [CW-1:0] x_r [2];
  logic signed [CW-1:0] y_r [2];
  logic signed [CW-1:0] z_r [2];
  logic [4:0]           cnt_r;
  logic [15:0]          radius_r;
  logic signed [17:0]   rc_r;
  logic signed [16:0]   px_r, py_r, pz_r;

  logic signed [CW-1:0] sin_v [2];
  logic signed [CW-1:0] cos_v [2];
  logic signed [51:0]   prod_rc, prod_sp, prod_x, prod_z;
  logic                 last_step;

  // Round a Q2.30 product half up and negate, then saturate to the output range.
  function automatic logic signed [16:0] neg_round_sat(input logic signed [51:0] p);
    logic signed [51:0] t;
    logic signed [22:0] v;
    t = (p + (52'sd1 <<< 29)) >>> 30;
    v = -t[22:0];
    if (v > 23'(ocp_pkg::POS_LIM)) begin
      v = 23'(ocp_pkg::POS_LIM);
    end else if (v < -23'(ocp_pkg::POS_LIM)) begin
      v = -23'(ocp_pkg::POS_LIM);
    end
    return v[16:0];
  endfunction

  // Sine and cosine per lane with the fold undone.
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      sin_v[k] = neg_r[k] ? -y_r[k] : y_r[k];
      cos_v[k] = neg_r[k] ? -x_r[k] : x_r[k];
    end
  end

  // Lane 0 is yaw, lane 1 is pitch.
  always_comb begin
    prod_rc = 52'(signed'({1'b0, radius_r})) * 52'(cos_v[1]);
    prod_sp = 52'(signed'({1'b0, radius_r})) * 52'(sin_v[1]);
    prod_x  = 52'(rc_r) * 52'(sin_v[0]);
    prod_z  = 52'(rc_r) * 52'(cos_v[0]);
  end

  assign last_step = (cnt_r == 5'(NSTEPS - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ocp_pkg::ST_IDLE: if (!q_empty) state_nxt = ocp_pkg::ST_FOLD;
      ocp_pkg::ST_FOLD: state_nxt = ocp_pkg::ST_ITER;
      ocp_pkg::ST_ITER: if (last_step) state_nxt = ocp_pkg::ST_MUL1;
      ocp_pkg::ST_MUL1: state_nxt = ocp_pkg::ST_MUL2;
      ocp_pkg::ST_MUL2: state_nxt = ocp_pkg::ST_OUT;
      ocp_pkg::ST_OUT:  if (out_ready) state_nxt = ocp_pkg::ST_IDLE;
      default:          state_nxt = ocp_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    q_pop     = (state_r == ocp_pkg::ST_IDLE) && !q_empty;
    out_valid = (state_r == ocp_pkg::ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ocp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      ocp_pkg::ST_IDLE: begin
        ang_r[0] <= q_data.yaw;
        ang_r[1] <= q_data.pitch;
        radius_r <= q_data.radius;
      end
      ocp_pkg::ST_FOLD: begin
        // Fold each angle into [-pi/2, pi/2] and seed the rotation.
        for (int k = 0; k < 2; k++) begin
          logic signed [16:0] a;
          logic               flip;
          a    = 17'(ang_r[k]);
          flip = 1'b0;
          if (a > 17'(ocp_pkg::ANG_HALF_PI)) begin
            a    = a - 17'(ocp_pkg::ANG_PI);
            flip = 1'b1;
          end else if (a < -17'(ocp_pkg::ANG_HALF_PI)) begin
            a    = a + 17'(ocp_pkg::ANG_PI);
            flip = 1'b1;
          end
          neg_r[k] <= flip;
          z_r[k] <= CW'(a) <<< 17;
          x_r[k] <= ocp_pkg::GAIN_Q30;
          y_r[k] <= '0;
        end
        cnt_r <= '0;
      end
      ocp_pkg::ST_ITER: begin
        // One micro-rotation per cycle on both lanes.
        for (int k = 0; k < 2; k++) begin
          if (!z_r[k][CW-1]) begin
            x_r[k] <= x_r[k] - (y_r[k] >>> cnt_r);
            y_r[k] <= y_r[k] + (x_r[k] >>> cnt_r);
            z_r[k] <= z_r[k] - ocp_pkg::atan_q30(cnt_r);
          end else begin
            x_r[k] <= x_r[k] + (y_r[k] >>> cnt_r);
            y_r[k] <= y_r[k] - (x_r[k] >>> cnt_r);
            z_r[k] <= z_r[k] + ocp_pkg::atan_q30(cnt_r);
          end
        end
        cnt_r <= cnt_r + 5'd1;
      end
      ocp_pkg::ST_MUL1: begin
        // r cos(p) rounded to Q8.8, and y from r sin(p).
        rc_r <= 18'((prod_rc + (52'sd1 <<< 29)) >>> 30);
        py_r <= neg_round_sat(prod_sp);
      end
      ocp_pkg::ST_MUL2: begin
        px_r <= neg_round_sat(prod_x);
        pz_r <= neg_round_sat(prod_z);
      end
      default: ;
    endcase
  end

  assign pos_x = px_r;
  assign pos_y = py_r;
  assign pos_z = pz_r;

  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == ocp_pkg::ST_FOLD) else $error("pop did not start an item");
  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ocp_pkg::ST_ITER |-> cnt_r < 5'(NSTEPS)) else $error("CORDIC overran");
  a_mul_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ocp_pkg::ST_MUL1 |=> state_r == ocp_pkg::ST_MUL2)
    else $error("multiply steps out of order");

endmodule

`default_nettype wire
